/* src/pcc_pkg.sv */
package pcc_pkg;

  localparam int unsigned EdgeW = 63;
  localparam int unsigned RootW = 64;
  localparam int unsigned SumW  = 2 * RootW;
  localparam int unsigned Lanes = 4;

  localparam int unsigned LaneAb    = 0;
  localparam int unsigned LaneBc    = 1;
  localparam int unsigned LaneAc    = 2;
  localparam int unsigned LaneSpace = 3;

  typedef struct packed {
    logic [EdgeW-1:0] side_a;
    logic [EdgeW-1:0] side_b;
    logic [EdgeW-1:0] side_c;
  } in_word_t;

  typedef struct packed {
    logic [RootW-1:0] root_ab;
    logic [RootW-1:0] root_bc;
    logic [RootW-1:0] root_ac;
    logic [RootW-1:0] root_abc;
    logic             square_ab;
    logic             square_bc;
    logic             square_ac;
    logic             square_space;
    logic             perfect_found;
  } out_word_t;

  // Partial remainder and partial root of one square-root lane.
  typedef struct packed {
    logic [SumW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_lane_t;

  // Try one root bit: t^2 - r^2 = (r << (k+1)) + (1 << 2k).
  function automatic sqrt_lane_t sqrt_step(sqrt_lane_t cur, int unsigned bit_pos);
    logic [SumW-1:0] trial;
    sqrt_lane_t      nxt;
    trial = ({{(SumW-RootW){1'b0}}, cur.root} << (bit_pos + 1))
          + ({{(SumW-1){1'b0}}, 1'b1} << (2 * bit_pos));
    nxt = cur;
    if (cur.rem >= trial) begin
      nxt.rem  = cur.rem - trial;
      nxt.root = cur.root | ({{(RootW-1){1'b0}}, 1'b1} << bit_pos);
    end
    return nxt;
  endfunction

endpackage

/* src/perfect_cuboid_check_core.sv */
// Perfect cuboid (Euler brick) checker, fully pipelined.
//
// Input channel in_valid/in_ready/in_data carries one word of three 63-bit
// edges. Output channel out_valid/out_ready/out_data carries the four floor
// roots of a^2+b^2, b^2+c^2, a^2+c^2 and a^2+b^2+c^2, a perfect-square flag
// for each sum, and perfect_found, the AND of the four flags.
//
// The pipeline has 68 register stages: one stage of 32x32 partial products, one
// stage to assemble the squares, one stage for the 128-bit sums, 64 stages
// of the bit-serial root (one root bit per stage, four lanes side by side)
// and the output register.
// Throughput is one word per cycle while the receiver takes results.
//
// The pipeline advances as a whole whenever the output register is empty or
// being read; when the receiver stalls with a result waiting, every stage
// holds and in_ready drops, so nothing is lost or repeated.
// Synchronous reset clears the valid bits only; out_valid is low after reset.
module perfect_cuboid_check_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pcc_pkg::out_word_t out_data
);
  import pcc_pkg::*;

  localparam int unsigned Steps = RootW;
  localparam int unsigned HalfW = 32;
  localparam int unsigned HighW = EdgeW - HalfW;

  // Advance every stage together; hold all of them while a result waits.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: partial products ----------------
  logic [EdgeW-1:0] side [0:2];
  assign side[0] = in_data.side_a;
  assign side[1] = in_data.side_b;
  assign side[2] = in_data.side_c;

  logic                   v1;
  logic [2*HalfW-1:0]     p00 [0:2];
  logic [HalfW+HighW-1:0] p01 [0:2];
  logic [2*HighW-1:0]     p11 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mul
    always_ff @(posedge clk) begin
      if (adv) begin
        p00[i] <= {{HalfW{1'b0}}, side[i][HalfW-1:0]}
                * {{HalfW{1'b0}}, side[i][HalfW-1:0]};
        p01[i] <= {{HighW{1'b0}}, side[i][HalfW-1:0]}
                * {{HalfW{1'b0}}, side[i][EdgeW-1:HalfW]};
        p11[i] <= {{HighW{1'b0}}, side[i][EdgeW-1:HalfW]}
                * {{HighW{1'b0}}, side[i][EdgeW-1:HalfW]};
      end
    end
  end

  // ---------------- stage 2: assemble squares ----------------
  // x^2 = hi^2 << 64 + (lo*hi) << 33 + lo^2
  logic            v2;
  logic [SumW-1:0] sq [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[i] <= {{(SumW-2*HighW-2*HalfW){1'b0}}, p11[i], {(2*HalfW){1'b0}}}
               + ({{(SumW-HalfW-HighW){1'b0}}, p01[i]} << (HalfW + 1))
               + {{(SumW-2*HalfW){1'b0}}, p00[i]};
      end
    end
  end

  // ---------------- stage 3: diagonal sums ----------------
  // lane[0] holds the sums with empty roots; lane[s] is after s root bits.
  logic       v [0:Steps];
  sqrt_lane_t lane [0:Steps][0:Lanes-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane[0][LaneAb]    <= '{rem: sq[0] + sq[1], root: '0};
      lane[0][LaneBc]    <= '{rem: sq[1] + sq[2], root: '0};
      lane[0][LaneAc]    <= '{rem: sq[0] + sq[2], root: '0};
      lane[0][LaneSpace] <= '{rem: sq[0] + sq[1] + sq[2], root: '0};
    end
  end

  // ---------------- root stages: one bit each, MSB first ----------------
  for (genvar s = 1; s <= Steps; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (adv) begin
        v[s] <= v[s-1];
      end
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (adv) begin
          lane[s][l] <= sqrt_step(lane[s-1][l], Steps - s);
        end
      end
    end
  end

  // ---------------- output register ----------------
  // A sum is a perfect square exactly when the final remainder is zero.
  logic [Lanes-1:0] exact;
  for (genvar l = 0; l < Lanes; l++) begin : g_exact
    assign exact[l] = (lane[Steps][l].rem == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.root_ab       <= lane[Steps][LaneAb].root;
      out_data.root_bc       <= lane[Steps][LaneBc].root;
      out_data.root_ac       <= lane[Steps][LaneAc].root;
      out_data.root_abc      <= lane[Steps][LaneSpace].root;
      out_data.square_ab     <= exact[LaneAb];
      out_data.square_bc     <= exact[LaneBc];
      out_data.square_ac     <= exact[LaneAc];
      out_data.square_space  <= exact[LaneSpace];
      out_data.perfect_found <= &exact;
    end
  end

endmodule

/* src/pcc_checker.sv */
module pcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input pcc_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pcc_pkg::out_word_t out_data
);
  import pcc_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // out_valid is low in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Take input exactly when the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_perfect: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.perfect_found ==
      (out_data.square_ab && out_data.square_bc &&
       out_data.square_ac && out_data.square_space))
    else $error("perfect_found is not the AND of the square flags");

  // The space sum dominates every face sum, so its root does too.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.root_abc >= out_data.root_ab &&
      out_data.root_abc >= out_data.root_bc &&
      out_data.root_abc >= out_data.root_ac)
    else $error("space root below a face root");

endmodule

bind perfect_cuboid_check_core pcc_checker u_pcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
